FILE: src/mbr_pkg.sv
// ----------------------------------------------------------------------------
// mbr_pkg: shared types and constants of the markup bracket rewriter
// Holds the command that the front end queues for the back end, the slot
// layout of one command and the fixed prefix and suffix byte strings.
// ----------------------------------------------------------------------------
package mbr_pkg;

	// Output slots of one command: lead byte, second byte, prefix, suffix
	localparam int SLOT_N = 14;
	localparam int SLOT_W = 4;

	localparam logic [SLOT_W-1:0] SLOT_A    = 4'd0;
	localparam logic [SLOT_W-1:0] SLOT_B    = 4'd1;
	localparam logic [SLOT_W-1:0] SLOT_PRE0 = 4'd2;
	localparam logic [SLOT_W-1:0] SLOT_SUF0 = 4'd9;
	localparam logic [SLOT_W-1:0] SLOT_LAST = 4'd13;

	localparam logic [SLOT_N-1:0] PRE_MASK = 14'h01FC;
	localparam logic [SLOT_N-1:0] SUF_MASK = 14'h3E00;

	// Configuration register indexes
	localparam logic CFG_OPEN  = 1'b0;
	localparam logic CFG_CLOSE = 1'b1;

	localparam logic [7:0] OPEN_RST  = 8'd91;
	localparam logic [7:0] CLOSE_RST = 8'd93;

	// Scan modes of the front end
	localparam logic [1:0] MODE_TEXT       = 2'd0;
	localparam logic [1:0] MODE_HELD_OPEN  = 2'd1;
	localparam logic [1:0] MODE_MARKUP     = 2'd2;
	localparam logic [1:0] MODE_HELD_CLOSE = 2'd3;

	// <%get("  and  ");%>
	localparam logic [7:0] PRE_CHARS [0:6] = '{8'h3C, 8'h25, 8'h67, 8'h65, 8'h74, 8'h28, 8'h22};
	localparam logic [7:0] SUF_CHARS [0:4] = '{8'h22, 8'h29, 8'h3B, 8'h25, 8'h3E};

	typedef struct packed {
		logic [7:0]        byte_a;
		logic [7:0]        byte_b;
		logic [SLOT_N-1:0] slots;
		logic              err;
		logic              last;
	} mbr_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mbr_qstat_t;

	// Byte carried by one slot of a command
	function automatic logic [7:0] mbr_slot_char(input logic [SLOT_W-1:0] k,
			input logic [7:0] a, input logic [7:0] b);
		logic [7:0] ch;
		begin
			if (k == SLOT_A) begin
				ch = a;
			end else if (k == SLOT_B) begin
				ch = b;
			end else if (k < SLOT_SUF0) begin
				ch = PRE_CHARS[3'(k - SLOT_PRE0)];
			end else if (k <= SLOT_LAST) begin
				ch = SUF_CHARS[3'(k - SLOT_SUF0)];
			end else begin
				ch = '0;
			end
			return ch;
		end
	endfunction

endpackage

FILE: src/mbr_in_if.sv
// ----------------------------------------------------------------------------
// mbr_in_if: input channel of the markup bracket rewriter
// Valid/ready channel carrying one page byte and its end-of-page mark.
// ----------------------------------------------------------------------------
interface mbr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_input;

	modport source (output valid, output in_char, output end_of_input, input ready);
	modport sink   (input valid, input in_char, input end_of_input, output ready);
endinterface

FILE: src/mbr_out_if.sv
// ----------------------------------------------------------------------------
// mbr_out_if: output channel of the markup bracket rewriter
// Valid/ready channel carrying one rewritten byte and its framing flags.
// ----------------------------------------------------------------------------
interface mbr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       run_last;
	logic       stream_last;
	logic       unclosed_error;

	modport source (output valid, output out_char, output run_last, output stream_last,
		output unclosed_error, input ready);
	modport sink   (input valid, input out_char, input run_last, input stream_last,
		input unclosed_error, output ready);
endinterface

FILE: src/mbr_front.sv
// ----------------------------------------------------------------------------
// mbr_front: scanner of the markup bracket rewriter
// Holds the delimiter registers and the scan mode, classifies each accepted
// byte and turns it into at most one command for the back end.
// ----------------------------------------------------------------------------
module mbr_front (
	input  logic               clk,
	input  logic               arst_n,
	mbr_in_if.sink             in_ch,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_wdata,
	input  mbr_pkg::mbr_qstat_t q_stat,
	output logic               push,
	output mbr_pkg::mbr_cmd_t  push_cmd,
	output logic [1:0]         scan_mode
);
	import mbr_pkg::*;

	logic [7:0] open_q;
	logic [7:0] close_q;
	logic [1:0] mode_q;
	logic [1:0] mode_nx;
	logic [1:0] mode_mid;
	logic       accept;
	mbr_cmd_t   cmd;

	assign in_ch.ready = !q_stat.full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign scan_mode   = mode_q;

	// Delimiter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= OPEN_RST;
			close_q <= CLOSE_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_OPEN) begin
				open_q <= cfg_wdata;
			end else begin
				close_q <= cfg_wdata;
			end
		end
	end

	// Classify the byte and build its command
	always_comb begin
		cmd      = '0;
		mode_mid = mode_q;
		case (mode_q)
			MODE_TEXT: begin
				if (in_ch.in_char == open_q) begin
					mode_mid = MODE_HELD_OPEN;
				end else begin
					cmd.byte_a       = in_ch.in_char;
					cmd.slots[SLOT_A] = 1'b1;
				end
			end
			MODE_HELD_OPEN: begin
				if (in_ch.in_char == open_q) begin
					cmd.slots = cmd.slots | PRE_MASK;
					mode_mid  = MODE_MARKUP;
				end else begin
					cmd.byte_a        = open_q;
					cmd.byte_b        = in_ch.in_char;
					cmd.slots[SLOT_A] = 1'b1;
					cmd.slots[SLOT_B] = 1'b1;
					mode_mid          = MODE_TEXT;
				end
			end
			MODE_MARKUP: begin
				if (in_ch.in_char == close_q) begin
					mode_mid = MODE_HELD_CLOSE;
				end else begin
					cmd.byte_a        = in_ch.in_char;
					cmd.slots[SLOT_A] = 1'b1;
				end
			end
			default: begin
				if (in_ch.in_char == close_q) begin
					cmd.slots = cmd.slots | SUF_MASK;
					mode_mid  = MODE_TEXT;
				end else begin
					cmd.byte_a        = close_q;
					cmd.byte_b        = in_ch.in_char;
					cmd.slots[SLOT_A] = 1'b1;
					cmd.slots[SLOT_B] = 1'b1;
					mode_mid          = MODE_MARKUP;
				end
			end
		endcase

		// End of page: flush a held delimiter, close an open span
		mode_nx  = mode_mid;
		cmd.last = in_ch.end_of_input;
		if (in_ch.end_of_input) begin
			case (mode_mid)
				MODE_HELD_OPEN: begin
					cmd.byte_a        = open_q;
					cmd.slots[SLOT_A] = 1'b1;
				end
				MODE_MARKUP: begin
					cmd.slots = cmd.slots | SUF_MASK;
					cmd.err   = 1'b1;
				end
				MODE_HELD_CLOSE: begin
					cmd.byte_a        = close_q;
					cmd.slots[SLOT_A] = 1'b1;
					cmd.slots         = cmd.slots | SUF_MASK;
					cmd.err           = 1'b1;
				end
				default: begin
				end
			endcase
			mode_nx = MODE_TEXT;
		end
	end

	// Only requests that produce output go to the queue
	assign push     = accept && (cmd.slots != '0);
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TEXT;
		end else if (accept) begin
			mode_q <= mode_nx;
		end
	end

endmodule

FILE: src/mbr_queue.sv
// ----------------------------------------------------------------------------
// mbr_queue: command queue of the markup bracket rewriter
// Small register FIFO between scanner and emitter; the head is visible
// combinationally to the emitter.
// ----------------------------------------------------------------------------
module mbr_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mbr_pkg::mbr_cmd_t   push_cmd,
	input  logic                pop,
	output mbr_pkg::mbr_cmd_t   head,
	output mbr_pkg::mbr_qstat_t q_stat
);
	import mbr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mbr_cmd_t       mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	assign q_stat.full  = (cnt_q == CW'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign head         = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: src/mbr_back.sv
// ----------------------------------------------------------------------------
// mbr_back: emitter of the markup bracket rewriter
// Walks the active slots of the head command into the output register, one
// byte per cycle while the output is not stalled, and pops the command after
// its last byte.
module mbr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mbr_pkg::mbr_cmd_t head,
	input  logic              head_valid,
	output logic              pop,
	mbr_out_if.source         out_ch
);
	import mbr_pkg::*;

	logic [SLOT_N-1:0] sent_q;
	logic [SLOT_N-1:0] left;
	logic [SLOT_N-1:0] rest;
	logic [SLOT_W-1:0] k;
	logic              load;
	logic              fire;
	logic              out_v_q;
	logic [7:0]        char_q;
	logic              run_last_q;
	logic              stream_last_q;
	logic              err_q;

	// Lowest slot not yet sent
	always_comb begin
		left = head.slots & ~sent_q;
		k    = '0;
		for (int i = SLOT_N - 1; i >= 0; i--) begin
			if (left[i]) begin
				k = SLOT_W'(i);
			end
		end
		rest = left & ~(SLOT_N'(1) << k);
	end

	assign load = !out_v_q || out_ch.ready;
	assign fire = load && head_valid;
	assign pop  = fire && (rest == '0);

	// Slot progress and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (fire) begin
				sent_q <= pop ? '0 : (sent_q | (SLOT_N'(1) << k));
			end
			if (load) begin
				out_v_q <= head_valid;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (fire) begin
			char_q        <= mbr_slot_char(k, head.byte_a, head.byte_b);
			run_last_q    <= pop;
			stream_last_q <= pop && head.last;
			err_q         <= head.err;
		end
	end

	assign out_ch.valid          = out_v_q;
	assign out_ch.out_char       = char_q;
	assign out_ch.run_last       = run_last_q;
	assign out_ch.stream_last    = stream_last_q;
	assign out_ch.unclosed_error = err_q;

endmodule

FILE: src/markup_bracket_rewriter.sv
// ----------------------------------------------------------------------------
// markup_bracket_rewriter: top level
// Rewrites doubled-delimiter markup spans of a byte stream into <%get("...");%>.
//
// in_ch takes one page byte per request, end_of_input on the last byte of a
// page. out_ch gives the rewritten bytes; run_last ends the bytes of one input
// request, stream_last ends the page, unclosed_error flags every byte of a
// final request whose page ended inside a markup span.
// cfg_we/cfg_index/cfg_wdata write open_delim (index 0) or close_delim
// (index 1); write only while the block is idle.
// Each result byte passes through the command queue and then the output
// register. The emitter sets the rate: one byte per cycle while the receiver
// is ready. Plain text flows at one input per cycle while the queue is not
// full; an input causing n bytes (up to 12) holds the emitter until its bytes
// are out, and the command queue (QUEUE_DEPTH entries) absorbs the input
// meanwhile; input stalls only once the queue is full.
// Inputs that cause no output (a held delimiter) never reach the emitter.
// Reset: delimiters return to '[' and ']', scan mode to plain text, queue and
// output register empty. A stalled receiver backs up the output register,
// then the queue, then in_ch.ready.
// ----------------------------------------------------------------------------
module markup_bracket_rewriter #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	mbr_in_if.sink     in_ch,
	mbr_out_if.source  out_ch,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata
);
	import mbr_pkg::*;

	logic       push;
	logic       pop;
	mbr_cmd_t   push_cmd;
	mbr_cmd_t   head;
	mbr_qstat_t q_stat;
	logic [1:0] scan_mode;

	mbr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_stat    (q_stat),
		.push      (push),
		.push_cmd  (push_cmd),
		.scan_mode (scan_mode)
	);

	mbr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	mbr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!q_stat.empty),
		.pop        (pop),
		.out_ch     (out_ch)
	);

	// A page end always leaves the scanner in plain text
	a_page_end_mode: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.end_of_input |=> scan_mode == MODE_TEXT)
		else $error("scan mode not cleared after page end");

	// Queue is never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("command queue overflow");

	// Nothing is popped from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("command queue underflow");

	// The page-final byte also closes its request
	a_stream_last_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.stream_last |-> out_ch.run_last)
		else $error("stream_last without run_last");

endmodule
